@@ hw/rtl/npc_pkg.sv @@
// Shared types, constants and character helpers for the natural path compare block.
package npc_pkg;

   localparam int MAX_LEN = 256;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CP_W    = 21;
   localparam int CSR_W   = 2;

   typedef enum logic [1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_COMPARE       = 2'd2
   } opcode_type;

   localparam logic [CSR_W-1:0] CSR_PATH_MODE     = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FOLDERS_FIRST = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DESCENDING    = 2'd2;

   typedef logic signed [1:0] ord_type;
   localparam ord_type ORD_LT = 2'sb11;
   localparam ord_type ORD_EQ = 2'sb00;
   localparam ord_type ORD_GT = 2'sb01;

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic signed [1:0] order;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic path_mode;
      logic folders_first;
      logic descending;
   } cfg_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_SLASH) || (c == CH_BSLASH);
   endfunction

   function automatic logic is_cont(input logic [7:0] c);
      return c[7:6] == 2'b10;
   endfunction

   // number of continuation bytes announced by a lead byte
   function automatic logic [1:0] utf_extra(input logic [7:0] c);
      logic [1:0] e;
      if (c >= 8'hF0)      e = 2'd3;
      else if (c >= 8'hE0) e = 2'd2;
      else if (c >= 8'hC0) e = 2'd1;
      else                 e = 2'd0;
      return e;
   endfunction

   function automatic ord_type apply_dir(input ord_type r, input logic neg);
      return neg ? ord_type'(2'sd0 - r) : r;
   endfunction

   // case-folded sort key; separators lowest
   function automatic logic [CP_W-1:0] fold_key(input logic [CP_W-1:0] cp);
      logic [CP_W-1:0] k;
      k = cp;
      if (cp == CP_W'(8'h2F) || cp == CP_W'(8'h5C))
         k = '0;
      else if (cp >= CP_W'(8'h41) && cp <= CP_W'(8'h5A))
         k = cp + CP_W'(8'h20);
      else if (cp >= CP_W'(16'h0410) && cp <= CP_W'(16'h042F))
         k = cp + CP_W'(8'h20);
      else if (cp == CP_W'(16'h0401) || cp == CP_W'(16'h0451))
         k = CP_W'(16'h0435);
      else if (cp >= CP_W'(16'h0400) && cp <= CP_W'(16'h040F))
         k = cp + CP_W'(8'h50);
      else if (cp >= CP_W'(8'hC0) && cp <= CP_W'(8'hDE) && cp != CP_W'(8'hD7))
         k = cp + CP_W'(8'h20);
      return k;
   endfunction

endpackage

@@ hw/rtl/npc_strbuf.sv @@
// String byte store: one write port, one read port with registered data.
module npc_strbuf (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [npc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [npc_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import npc_pkg::*;

   logic [7:0] mem [MAX_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/npc_seq.sv @@
// Compare sequencer: walks both string stores one byte per side per cycle.
module npc_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  npc_pkg::cfg_type           cfg,
   input  logic [npc_pkg::LEN_W-1:0]  len_a,
   input  logic [npc_pkg::LEN_W-1:0]  len_b,
   input  logic [7:0]                 rd_a,
   input  logic [7:0]                 rd_b,
   output logic [npc_pkg::ADDR_W-1:0] addr_a,
   output logic [npc_pkg::ADDR_W-1:0] addr_b,
   output logic                       busy,
   output logic                       done,
   output npc_pkg::ord_type           order
);
   import npc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SEP, S_PFX, S_BO1, S_BO2, S_LOOP, S_ZS, S_DW,
      S_DEC0, S_DEC1, S_RAW, S_FIN
   } state_type;

   state_type       state_ff, state_in;
   logic [LEN_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [LEN_W-1:0] sta_ff, sta_in, stb_ff, stb_in;
   logic [LEN_W-1:0] ena_ff, ena_in, enb_ff, enb_in;
   logic            dna_ff, dna_in, dnb_ff, dnb_in;
   logic            za_ff, za_in, zb_ff, zb_in;
   ord_type         diff_ff, diff_in, res_ff, res_in;
   logic [1:0]      rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [CP_W-1:0] cpa_ff, cpa_in, cpb_ff, cpb_in;

   logic            nat_end;
   ord_type         nat_r;
   logic            a_rng, b_rng, dig_a, dig_b, go_a, go_b, fin_a, fin_b, cont_now;
   logic [1:0]      ext_a, ext_b;
   logic [CP_W-1:0] key_a, key_b;
   logic            dir_neg;

   always_comb begin
      state_in = state_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      sta_in   = sta_ff;
      stb_in   = stb_ff;
      ena_in   = ena_ff;
      enb_in   = enb_ff;
      dna_in   = dna_ff;
      dnb_in   = dnb_ff;
      za_in    = za_ff;
      zb_in    = zb_ff;
      diff_in  = diff_ff;
      res_in   = res_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      cpa_in   = cpa_ff;
      cpb_in   = cpb_ff;
      nat_end  = 1'b0;
      nat_r    = ORD_EQ;
      dir_neg  = cfg.path_mode && cfg.descending;
      a_rng    = pa_ff < ena_ff;
      b_rng    = pb_ff < enb_ff;
      dig_a    = is_dig(rd_a);
      dig_b    = is_dig(rd_b);
      go_a     = 1'b0;
      go_b     = 1'b0;
      fin_a    = 1'b0;
      fin_b    = 1'b0;
      cont_now = 1'b0;
      ext_a    = utf_extra(rd_a);
      ext_b    = utf_extra(rd_b);
      key_a    = fold_key(cpa_ff);
      key_b    = fold_key(cpb_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               pa_in    = '0;
               pb_in    = '0;
               sta_in   = '0;
               stb_in   = '0;
               ena_in   = len_a;
               enb_in   = len_b;
               state_in = cfg.path_mode ? S_SEP : S_PFX;
            end
         end
         S_SEP: begin
            // a side that hit its separator or end stays put
            go_a = (pa_ff < len_a) && !is_sep(rd_a);
            go_b = (pb_ff < len_b) && !is_sep(rd_b);
            if (go_a) pa_in = pa_ff + 1'b1;
            if (go_b) pb_in = pb_ff + 1'b1;
            if (!go_a && !go_b) begin
               ena_in = pa_ff;
               enb_in = pb_ff;
               if ((pa_ff == len_a) != (pb_ff == len_b)) begin
                  res_in   = ((pa_ff == len_a) == cfg.folders_first) ? ORD_GT : ORD_LT;
                  state_in = S_FIN;
               end else begin
                  pa_in    = sta_ff;
                  pb_in    = stb_ff;
                  state_in = S_PFX;
               end
            end
         end
         S_PFX: begin
            if (a_rng && b_rng && rd_a == rd_b) begin
               pa_in = pa_ff + 1'b1;
               pb_in = pb_ff + 1'b1;
            end else begin
               state_in = (pa_ff > sta_ff) ? S_BO1 : S_LOOP;
            end
         end
         S_BO1: begin
            // back off out of a multibyte char or a digit run
            cont_now = (a_rng && is_cont(rd_a)) || (b_rng && is_cont(rd_b));
            if (cont_now) begin
               pa_in    = pa_ff - 1'b1;
               pb_in    = pb_ff - 1'b1;
               state_in = (pa_ff > sta_ff + 1'b1) ? S_BO1 : S_LOOP;
            end else begin
               pb_in    = pb_ff - 1'b1;
               state_in = S_BO2;
            end
         end
         S_BO2: begin
            // rd_b holds the shared byte just before the split point
            if (dig_b) begin
               pa_in    = pa_ff - 1'b1;
               state_in = (pa_ff > sta_ff + 1'b1) ? S_BO1 : S_LOOP;
            end else begin
               pb_in    = pb_ff + 1'b1;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (!(a_rng && b_rng)) begin
               nat_end = 1'b1;
               nat_r   = a_rng ? ORD_GT : (b_rng ? ORD_LT : ORD_EQ);
            end else if (dig_a && dig_b) begin
               dna_in   = 1'b0;
               dnb_in   = 1'b0;
               za_in    = 1'b0;
               zb_in    = 1'b0;
               state_in = S_ZS;
            end else begin
               state_in = S_DEC0;
            end
         end
         S_ZS: begin
            // strip leading zeros, keeping the last one of an all-zero run
            fin_a = dna_ff || !(a_rng && rd_a == CH_ZERO);
            fin_b = dnb_ff || !(b_rng && rd_b == CH_ZERO);
            if (!dna_ff) begin
               if (!fin_a) begin
                  pa_in = pa_ff + 1'b1;
                  za_in = 1'b1;
               end else begin
                  if (za_ff && !(a_rng && dig_a)) pa_in = pa_ff - 1'b1;
                  dna_in = 1'b1;
               end
            end
            if (!dnb_ff) begin
               if (!fin_b) begin
                  pb_in = pb_ff + 1'b1;
                  zb_in = 1'b1;
               end else begin
                  if (zb_ff && !(b_rng && dig_b)) pb_in = pb_ff - 1'b1;
                  dnb_in = 1'b1;
               end
            end
            if (fin_a && fin_b) begin
               diff_in  = ORD_EQ;
               state_in = S_DW;
            end
         end
         S_DW: begin
            go_a = a_rng && dig_a;
            go_b = b_rng && dig_b;
            if (go_a && go_b) begin
               if (diff_ff == ORD_EQ && rd_a != rd_b) diff_in = (rd_a < rd_b) ? ORD_LT : ORD_GT;
               pa_in = pa_ff + 1'b1;
               pb_in = pb_ff + 1'b1;
            end else if (go_a) begin
               nat_end = 1'b1;
               nat_r   = ORD_GT;
            end else if (go_b) begin
               nat_end = 1'b1;
               nat_r   = ORD_LT;
            end else if (diff_ff != ORD_EQ) begin
               nat_end = 1'b1;
               nat_r   = diff_ff;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_DEC0: begin
            if (({1'b0, pa_ff} + (LEN_W+1)'(ext_a)) >= {1'b0, ena_ff}) ext_a = 2'd0;
            if (({1'b0, pb_ff} + (LEN_W+1)'(ext_b)) >= {1'b0, enb_ff}) ext_b = 2'd0;
            cpa_in   = CP_W'((ext_a == 2'd0) ? rd_a : (rd_a & (8'h3F >> ext_a)));
            cpb_in   = CP_W'((ext_b == 2'd0) ? rd_b : (rd_b & (8'h3F >> ext_b)));
            rem_a_in = ext_a;
            rem_b_in = ext_b;
            pa_in    = pa_ff + 1'b1;
            pb_in    = pb_ff + 1'b1;
            state_in = S_DEC1;
         end
         S_DEC1: begin
            if (rem_a_ff != 2'd0) begin
               cpa_in   = {cpa_ff[CP_W-7:0], rd_a[5:0]};
               rem_a_in = rem_a_ff - 1'b1;
               pa_in    = pa_ff + 1'b1;
            end
            if (rem_b_ff != 2'd0) begin
               cpb_in   = {cpb_ff[CP_W-7:0], rd_b[5:0]};
               rem_b_in = rem_b_ff - 1'b1;
               pb_in    = pb_ff + 1'b1;
            end
            if (rem_a_ff == 2'd0 && rem_b_ff == 2'd0) begin
               if (key_a != key_b) begin
                  nat_end = 1'b1;
                  nat_r   = (key_a < key_b) ? ORD_LT : ORD_GT;
               end else begin
                  state_in = S_LOOP;
               end
            end
         end
         S_RAW: begin
            if ((pa_ff < len_a) && (pb_ff < len_b)) begin
               if (rd_a != rd_b) begin
                  res_in   = apply_dir((rd_a < rd_b) ? ORD_LT : ORD_GT, dir_neg);
                  state_in = S_FIN;
               end else begin
                  pa_in = pa_ff + 1'b1;
                  pb_in = pb_ff + 1'b1;
               end
            end else begin
               res_in   = apply_dir((len_a == len_b) ? ORD_EQ :
                                    ((len_a < len_b) ? ORD_LT : ORD_GT), dir_neg);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of one natural compare: decide, go to next level, or fall to raw bytes
      if (nat_end) begin
         if (nat_r != ORD_EQ) begin
            res_in   = apply_dir(nat_r, dir_neg);
            state_in = S_FIN;
         end else if (!cfg.path_mode || ena_ff == len_a) begin
            pa_in    = '0;
            pb_in    = '0;
            state_in = S_RAW;
         end else begin
            pa_in    = ena_ff + 1'b1;
            pb_in    = enb_ff + 1'b1;
            sta_in   = ena_ff + 1'b1;
            stb_in   = enb_ff + 1'b1;
            state_in = S_SEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= ORD_EQ;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      sta_ff   <= sta_in;
      stb_ff   <= stb_in;
      ena_ff   <= ena_in;
      enb_ff   <= enb_in;
      dna_ff   <= dna_in;
      dnb_ff   <= dnb_in;
      za_ff    <= za_in;
      zb_ff    <= zb_in;
      diff_ff  <= diff_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      cpa_ff   <= cpa_in;
      cpb_ff   <= cpb_in;
   end

   // read address follows the next pointer so read data matches the pointer
   assign addr_a = pa_in[ADDR_W-1:0];
   assign addr_b = pb_in[ADDR_W-1:0];
   assign busy   = state_ff != S_IDLE;
   assign done   = state_ff == S_FIN;
   assign order  = res_ff;

endmodule

@@ hw/rtl/natural_path_compare_top.sv @@
// Top level of the natural path compare block: command port, registers, string stores.
//
// Command channel: an item transfers at a rising edge with start high and busy low.
// Opcode append-first / append-second stores req_item.byte_value and
// gives no result; busy stays low, so appends may come every cycle. A full store
// drops the byte and sets the overflow flag. Opcode compare raises busy and the
// sequencer walks both stores, one byte per side per cycle through each store's
// single read port. The result strobe rsp_valid is high for one cycle at the end
// of the compare with rsp_item.order and rsp_item.overflow, and busy falls the
// cycle after. The compare empties both strings and clears overflow.
// The receiver cannot stall the result. Unused opcodes are taken and ignored.
// CSR writes transfer when csr_valid and csr_ready are high; csr_ready is low
// while busy. Reset: both strings empty, overflow clear, path_mode = 1,
// folders_first = 1, descending = 0. Store contents are not cleared.
module natural_path_compare_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  npc_pkg::req_type          req_item,
   output logic                      rsp_valid,
   output npc_pkg::rsp_type          rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [npc_pkg::CSR_W-1:0] csr_index,
   input  logic                      csr_data
);
   import npc_pkg::*;

   logic [LEN_W-1:0] a_len_ff, a_len_in, b_len_ff, b_len_in;
   logic             ovf_ff, ovf_in;
   cfg_type          cfg_ff, cfg_in;

   logic             accept, app_a, app_b, full_a, full_b, go;
   logic             seq_busy, seq_done;
   ord_type          seq_order;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [7:0]       rd_a, rd_b;

   assign accept = start && !busy;
   assign app_a  = accept && req_item.opcode == OP_APPEND_FIRST;
   assign app_b  = accept && req_item.opcode == OP_APPEND_SECOND;
   assign go     = accept && req_item.opcode == OP_COMPARE;
   assign full_a = a_len_ff == LEN_W'(MAX_LEN);
   assign full_b = b_len_ff == LEN_W'(MAX_LEN);

   always_comb begin
      a_len_in = a_len_ff;
      b_len_in = b_len_ff;
      ovf_in   = ovf_ff;
      cfg_in   = cfg_ff;
      if (seq_done) begin
         a_len_in = '0;
         b_len_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (app_a && !full_a) a_len_in = a_len_ff + 1'b1;
         if (app_b && !full_b) b_len_in = b_len_ff + 1'b1;
         if ((app_a && full_a) || (app_b && full_b)) ovf_in = 1'b1;
      end
      if (csr_valid && csr_ready) begin
         priority case (csr_index)
            CSR_PATH_MODE:     cfg_in.path_mode     = csr_data;
            CSR_FOLDERS_FIRST: cfg_in.folders_first = csr_data;
            CSR_DESCENDING:    cfg_in.descending    = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_len_ff <= '0;
         b_len_ff <= '0;
         ovf_ff   <= 1'b0;
         cfg_ff   <= '{path_mode: 1'b1, folders_first: 1'b1, descending: 1'b0};
      end else begin
         a_len_ff <= a_len_in;
         b_len_ff <= b_len_in;
         ovf_ff   <= ovf_in;
         cfg_ff   <= cfg_in;
      end
   end

   npc_strbuf u_buf_a (
      .clock   (clock),
      .wr_en   (app_a && !full_a),
      .wr_addr (a_len_ff[ADDR_W-1:0]),
      .wr_data (req_item.byte_value),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   npc_strbuf u_buf_b (
      .clock   (clock),
      .wr_en   (app_b && !full_b),
      .wr_addr (b_len_ff[ADDR_W-1:0]),
      .wr_data (req_item.byte_value),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   npc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .cfg    (cfg_ff),
      .len_a  (a_len_ff),
      .len_b  (b_len_ff),
      .rd_a   (rd_a),
      .rd_b   (rd_b),
      .addr_a (addr_a),
      .addr_b (addr_b),
      .busy   (seq_busy),
      .done   (seq_done),
      .order  (seq_order)
   );

   assign busy              = seq_busy;
   assign csr_ready         = !seq_busy;
   assign rsp_valid         = seq_done;
   assign rsp_item.order    = seq_order;
   assign rsp_item.overflow = ovf_ff;

`ifndef SYNTHESIS
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a compare");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (a_len_ff == '0 && b_len_ff == '0 && !ovf_ff))
      else $error("strings not cleared after compare");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (a_len_ff <= LEN_W'(MAX_LEN)) && (b_len_ff <= LEN_W'(MAX_LEN)))
      else $error("string length past capacity");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy) else $error("compare did not start");
`endif

endmodule

@@ dv/natural_path_compare_top_tb.sv @@
// Self-checking testbench for natural_path_compare_top: natural and path-level string ordering.
`timescale 1ns / 100ps

module natural_path_compare_top_tb;
   import npc_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;

   typedef logic [7:0] str_buf [0:MAX_LEN-1];
   typedef logic [7:0] byte_q [$];

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [CSR_W-1:0] csr_index = '0;
   logic    csr_data = 0;

   natural_path_compare_top dut (.*);

   always #4 clock = ~clock;

   // shadow state of the block
   str_buf  first_bytes, second_bytes;
   int      first_len, second_len;
   logic    dropped;
   cfg_type shadow_cfg;
   rsp_type order_q [$];

   int items_sent, compares_sent, results_seen, mismatches, cycles;
   bit burst;

   // ---------------- ordering predictor ----------------
   function automatic bit digit_ch(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit sep_ch(logic [7:0] c);
      return c == 8'h2F || c == 8'h5C;
   endfunction

   function automatic int decode_at(input str_buf s, input int base, input int n,
                                    input int p, output int nxt);
      int extra, cp;
      logic [7:0] lead;
      lead  = s[base+p];
      extra = lead >= 8'hF0 ? 3 : lead >= 8'hE0 ? 2 : lead >= 8'hC0 ? 1 : 0;
      if (p + extra >= n) extra = 0;
      cp = extra == 0 ? lead : (lead & (8'h3F >> extra));
      for (int t = 1; t <= extra; t++) cp = (cp << 6) | (s[base+p+t] & 8'h3F);
      nxt = p + 1 + extra;
      return cp;
   endfunction

   function automatic int sort_key(int cp);
      if (cp == 'h2F || cp == 'h5C) return 0;
      if (cp >= 'h41 && cp <= 'h5A) return cp + 'h20;
      if (cp >= 'h410 && cp <= 'h42F) return cp + 'h20;
      if (cp == 'h401 || cp == 'h451) return 'h435;
      if (cp >= 'h400 && cp <= 'h40F) return cp + 'h50;
      if (cp >= 'hC0 && cp <= 'hDE && cp != 'hD7) return cp + 'h20;
      return cp;
   endfunction

   function automatic int bytewise_order(input str_buf a, input int na,
                                         input str_buf b, input int nb);
      for (int k = 0; k < na && k < nb; k++)
         if (a[k] != b[k]) return a[k] < b[k] ? -1 : 1;
      if (na != nb) return na < nb ? -1 : 1;
      return 0;
   endfunction

   function automatic int natural_order(input str_buf a, input int a0, input int na,
                                        input str_buf b, input int b0, input int nb);
      int k, i, j, ea, eb, la, lb, ka, kb;
      k = 0;
      while (k < na && k < nb && a[a0+k] == b[b0+k]) k++;
      // back up out of a multibyte character or a digit run
      while (k > 0 && ((k < na && a[a0+k][7:6] == 2'b10) ||
                       (k < nb && b[b0+k][7:6] == 2'b10) || digit_ch(a[a0+k-1]))) k--;
      i = k;
      j = k;
      while (i < na && j < nb) begin
         if (digit_ch(a[a0+i]) && digit_ch(b[b0+j])) begin
            ea = i;
            eb = j;
            while (ea < na && digit_ch(a[a0+ea])) ea++;
            while (eb < nb && digit_ch(b[b0+eb])) eb++;
            while (i + 1 < ea && a[a0+i] == 8'h30) i++;
            while (j + 1 < eb && b[b0+j] == 8'h30) j++;
            la = ea - i;
            lb = eb - j;
            if (la != lb) return la < lb ? -1 : 1;
            for (int t = 0; t < la; t++)
               if (a[a0+i+t] != b[b0+j+t]) return a[a0+i+t] < b[b0+j+t] ? -1 : 1;
            i = ea;
            j = eb;
         end else begin
            ka = sort_key(decode_at(a, a0, na, i, i));
            kb = sort_key(decode_at(b, b0, nb, j, j));
            if (ka != kb) return ka < kb ? -1 : 1;
         end
      end
      if (i < na) return 1;
      if (j < nb) return -1;
      return 0;
   endfunction

   function automatic int level_order(input str_buf a, input int na,
                                      input str_buf b, input int nb, input cfg_type cfg);
      int dir, i, j, ea, eb, c;
      bit fa, fb;
      dir = cfg.descending ? -1 : 1;
      i = 0;
      j = 0;
      forever begin
         ea = i;
         eb = j;
         while (ea < na && !sep_ch(a[ea])) ea++;
         while (eb < nb && !sep_ch(b[eb])) eb++;
         fa = ea == na;
         fb = eb == nb;
         if (fa != fb) return fa == cfg.folders_first ? 1 : -1;
         c = natural_order(a, i, ea - i, b, j, eb - j);
         if (c != 0) return c * dir;
         if (fa) break;
         i = ea + 1;
         j = eb + 1;
      end
      return bytewise_order(a, na, b, nb) * dir;
   endfunction

   function automatic void apply_item(logic [1:0] op, logic [7:0] b);
      int r;
      rsp_type e;
      if (op == OP_APPEND_FIRST) begin
         if (first_len < MAX_LEN) first_bytes[first_len++] = b;
         else dropped = 1;
      end else if (op == OP_APPEND_SECOND) begin
         if (second_len < MAX_LEN) second_bytes[second_len++] = b;
         else dropped = 1;
      end else if (op == OP_COMPARE) begin
         if (shadow_cfg.path_mode) begin
            r = level_order(first_bytes, first_len, second_bytes, second_len, shadow_cfg);
         end else begin
            r = natural_order(first_bytes, 0, first_len, second_bytes, 0, second_len);
            if (r == 0) r = bytewise_order(first_bytes, first_len, second_bytes, second_len);
         end
         e.order    = r < 0 ? ORD_LT : r > 0 ? ORD_GT : ORD_EQ;
         e.overflow = dropped;
         order_q.push_back(e);
         first_len  = 0;
         second_len = 0;
         dropped    = 0;
         compares_sent++;
      end
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, order_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (order_q.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result order=%0d", rsp_item.order);
         end else begin
            if (rsp_item.order !== order_q[0].order ||
                rsp_item.overflow !== order_q[0].overflow) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("result %0d: expected order=%0d overflow=%0b, got order=%0d overflow=%0b",
                           results_seen, order_q[0].order, order_q[0].overflow,
                           rsp_item.order, rsp_item.overflow);
            end
            void'(order_q.pop_front());
         end
      end
   end

   // ---------------- drivers (all tasks return at a falling edge) ----------------
   task automatic send_item(logic [1:0] op, logic [7:0] b);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 17);
      repeat (gap) @(negedge clock);
      start = 1;
      req_item.opcode     = opcode_type'(op);
      req_item.byte_value = b;
      do @(posedge clock); while (busy);
      apply_item(op, b);
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
      start = 0;
   endtask

   task automatic wait_drained();
      while (order_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] idx, logic val);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATH_MODE:     shadow_cfg.path_mode     = val;
         CSR_FOLDERS_FIRST: shadow_cfg.folders_first = val;
         CSR_DESCENDING:    shadow_cfg.descending    = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_mode(logic pm, logic ff, logic desc);
      wait_drained();
      write_reg(CSR_PATH_MODE, pm);
      write_reg(CSR_FOLDERS_FIRST, ff);
      write_reg(CSR_DESCENDING, desc);
   endtask

   // loads both strings, interleaving the two append streams, then compares
   task automatic compare_pair(byte_q a, byte_q b);
      while (a.size() || b.size()) begin
         if (a.size() && (b.size() == 0 || $urandom_range(0, 1)))
            send_item(OP_APPEND_FIRST, a.pop_front());
         else
            send_item(OP_APPEND_SECOND, b.pop_front());
      end
      send_item(OP_COMPARE, 8'($urandom_range(0, 255)));
   endtask

   function automatic byte_q to_bytes(string s);
      byte_q q;
      for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
      return q;
   endfunction

   // ---------------- random name generator ----------------
   task automatic add_token(inout byte_q q);
      int n;
      case ($urandom_range(0, 10))
         0, 1: begin
            repeat ($urandom_range(0, 2)) q.push_back(8'h30);
            n = $urandom_range(1, 4);
            repeat (n) q.push_back(8'(8'h30 + $urandom_range(0, 9)));
         end
         2: q.push_back(8'(8'h61 + $urandom_range(0, 25)));
         3: q.push_back(8'(8'h41 + $urandom_range(0, 25)));
         4: q.push_back($urandom_range(0, 1) ? 8'h2F : 8'h5C);
         5: begin
            n = 'h400 + $urandom_range(0, 'h5F);
            q.push_back(8'(8'hC0 | (n >> 6)));
            q.push_back(8'(8'h80 | (n & 'h3F)));
         end
         6: begin
            q.push_back(8'hC3);
            q.push_back(8'(8'h80 + $urandom_range(0, 'h3F)));
         end
         7: q.push_back(8'($urandom_range(0, 255)));
         8: begin
            q.push_back(8'hE2);
            q.push_back(8'h82);
            q.push_back(8'hAC);
         end
         9: begin
            q.push_back(8'(8'hF0 + $urandom_range(0, 15)));
            repeat ($urandom_range(0, 3)) q.push_back(8'(8'h80 + $urandom_range(0, 'h7F)));
         end
         default: q.push_back(8'h2E);
      endcase
   endtask

   task automatic make_pair(output byte_q a, output byte_q b);
      int n, pos;
      a = {};
      n = $urandom_range(0, 49) == 0 ? $urandom_range(60, 200) : $urandom_range(0, 7);
      repeat (n) add_token(a);
      b = a;
      case ($urandom_range(0, 5))
         0: ;
         1: if (b.size()) begin
            pos = $urandom_range(0, b.size() - 1);
            b[pos] = $urandom_range(0, 1) ? 8'(8'h30 + $urandom_range(0, 9))
                                          : 8'(8'h41 + $urandom_range(0, 57));
         end
         2: begin
            b = {};
            repeat ($urandom_range(0, 7)) add_token(b);
         end
         3: foreach (b[k])
            if ((b[k] >= 8'h41 && b[k] <= 8'h5A) || (b[k] >= 8'h61 && b[k] <= 8'h7A))
               b[k] = b[k] ^ 8'h20;
         4: add_token(b);
         default: if (b.size()) b = b[0:$urandom_range(0, b.size() - 1)];
      endcase
      if ($urandom_range(0, 1)) begin
         byte_q t;
         t = a;
         a = b;
         b = t;
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_state();
      // reset settings: path mode, folders first, ascending
      send_item(OP_COMPARE, 8'hFF);
      send_item(OP_UNUSED, 8'hA5);
      compare_pair(to_bytes("B"), to_bytes("a"));
   endtask

   task automatic test_digit_runs();
      compare_pair(to_bytes("a10"), to_bytes("a9"));
      compare_pair(to_bytes("007"), to_bytes("7"));
   endtask

   task automatic test_partial_utf8();
      compare_pair({8'h61, 8'hD0}, {8'h61, 8'hD0, 8'h90});
      compare_pair({8'hD1, 8'h91}, {8'hD0, 8'hB5});
   endtask

   task automatic test_file_vs_folder();
      set_mode(1, 0, 1);
      compare_pair(to_bytes("a/b"), to_bytes("c"));
      compare_pair(to_bytes("x\\b"), to_bytes("x/a"));
      set_mode(0, 1, 1);
      compare_pair(to_bytes("a/b"), to_bytes("ab"));
   endtask

   task automatic test_overflow();
      burst = 1;
      repeat (MAX_LEN + 2) send_item(OP_APPEND_FIRST, 8'($urandom_range(0, 255)));
      send_item(OP_APPEND_SECOND, 8'h00);
      send_item(OP_COMPARE, 8'h00);
      repeat (MAX_LEN + 1) send_item(OP_APPEND_SECOND, 8'h7A);
      send_item(OP_COMPARE, 8'h00);
      burst = 0;
   endtask

   task automatic test_random(int target);
      byte_q a, b;
      int per_mode;
      per_mode = target / 8;
      for (int m = 0; m < 8; m++) begin
         set_mode(m[2], m[1], m[0]);
         for (int base = items_sent; items_sent - base < per_mode; ) begin
            burst = $urandom_range(0, 3) == 0;
            make_pair(a, b);
            if ($urandom_range(0, 9) == 0) send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 11) == 0) wait_drained();
            compare_pair(a, b);
         end
      end
      burst = 0;
   endtask

   initial begin
      first_len  = 0;
      second_len = 0;
      dropped    = 0;
      shadow_cfg = '{path_mode: 1, folders_first: 1, descending: 0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_reset_state();
      test_digit_runs();
      test_partial_utf8();
      test_file_vs_folder();
      test_overflow();
      test_random(950 - items_sent);

      wait_drained();
      repeat (40) @(negedge clock);
      $display("Covered %0d loaded bytes and compares (%0d compares), %0d results checked,",
               items_sent, compares_sent, results_seen);
      $display("all eight register settings, overflow and file/folder cases.");
      if (mismatches == 0 && order_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, order_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/npc_pkg.sv
hw/rtl/npc_strbuf.sv
hw/rtl/npc_seq.sv
hw/rtl/natural_path_compare_top.sv
dv/natural_path_compare_top_tb.sv
